// ===== design/haptic_pattern_sequencer_defines.svh =====
// Assertion macros for the checker file of the haptic pattern sequencer.
// Each macro expects a signal named clk in its scope; HPS_ASSERT also needs rst_n.
`ifndef HAPTIC_PATTERN_SEQUENCER_DEFINES_SVH
`define HAPTIC_PATTERN_SEQUENCER_DEFINES_SVH

// Property checked outside reset only.
`define HPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define HPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/haps_pkg.sv =====
package haps_pkg;

  localparam int TICK_COUNT_WIDTH_DEF = 7;
  localparam int CFG_ADDR_W           = 3;
  localparam int CFG_DATA_W           = 32;

  // Configuration register indexes
  localparam logic REG_PULSES_PER_SET = 1'b0;
  localparam logic REG_LEVEL_LIMIT    = 1'b1;

  localparam logic [3:0] PPS_RESET   = 4'd3;
  localparam logic [3:0] LIMIT_RESET = 4'd12;

  typedef enum logic [1:0] {
    REQ_TICK          = 2'd0,
    REQ_START         = 2'd1,
    REQ_START_CONFIRM = 2'd2,
    REQ_STOP          = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    MODE_IDLE        = 4'd0,
    MODE_ON          = 4'd1,
    MODE_OFF         = 4'd2,
    MODE_WEAK        = 4'd3,
    MODE_DURING      = 4'd4,
    MODE_DURING_REP  = 4'd5,
    MODE_STRONG      = 4'd6,
    MODE_STRONG_REP  = 4'd7,
    MODE_RISING      = 4'd8,
    MODE_STANDBY     = 4'd9,
    MODE_SENSING     = 4'd10,
    MODE_PAUSE       = 4'd11,
    MODE_LEVEL_PAUSE = 4'd12
  } mode_t;

  typedef struct packed {
    logic [3:0] pulses_per_set;
    logic [3:0] level_limit;
  } cfg_t;

  typedef struct packed {
    mode_t      mode;
    mode_t      return_mode;
    logic [3:0] strength_level;
    logic [5:0] pulse_count;
    logic [5:0] pulse_target;
    logic       stopped;
    logic       confirm_mode;
    logic       line_ctl;
    logic       line_ena;
    logic       busy;
  } seq_state_t;

  localparam seq_state_t ST_RESET = '{
    mode:           MODE_IDLE,
    return_mode:    MODE_IDLE,
    strength_level: 4'd0,
    pulse_count:    6'd0,
    pulse_target:   6'(PPS_RESET),
    stopped:        1'b0,
    confirm_mode:   1'b0,
    line_ctl:       1'b0,
    line_ena:       1'b0,
    busy:           1'b0
  };

  // Pulse timing in ticks: period, enable-off point, control-off point.
  localparam logic [6:0] T_PERIOD_A = 7'd20;
  localparam logic [6:0] T_ENA_A    = 7'd13;
  localparam logic [6:0] T_CTL_A    = 7'd11;
  localparam logic [6:0] T_PERIOD_B = 7'd28;
  localparam logic [6:0] T_ENA_B    = 7'd21;
  localparam logic [6:0] T_CTL_B    = 7'd19;
  localparam logic [6:0] T_PERIOD_C = 7'd30;
  localparam logic [6:0] T_ENA_C    = 7'd29;
  localparam logic [6:0] T_CTL_C    = 7'd27;
  localparam logic [6:0] T_PERIOD_D = 7'd38;
  localparam logic [6:0] T_ENA_D    = 7'd37;
  localparam logic [6:0] T_CTL_D    = 7'd35;
  localparam logic [6:0] T_STANDBY  = 7'd80;
  localparam logic [6:0] T_SENSING  = 7'd10;
  localparam logic [6:0] T_PAUSE    = 7'd20;
  localparam logic [6:0] T_LVL_PAUSE = 7'd40;

  // Divisibility table: bit m of row d is set when m is a multiple of d.
  // Row zero behaves as a divisor of one.
  typedef logic [63:0]           div_row_t;
  typedef div_row_t [15:0]       div_tab_t;

  function automatic div_tab_t build_div_tab();
    div_tab_t tab;
    int       stride;
    tab = '0;
    for (int d = 0; d < 16; d++) begin
      stride = (d == 0) ? 1 : d;
      for (int m = 0; m < 64; m += stride) begin
        tab[d][m] = 1'b1;
      end
    end
    return tab;
  endfunction

  localparam div_tab_t DIV_TAB = build_div_tab();

endpackage

// ===== design/haptic_pattern_sequencer.sv =====
// Haptic pattern sequencer: drives the control and enable lines of a vibration motor.
// Input channel (in_*): one transfer per request. A tick transfer stands for 10 ms of
// time; the others start a pattern, start one with the confirm step-up, or stop it.
// Result channel (out_*): exactly one transfer per input transfer, in order, giving the
// motor lines, the busy flag, the finished pulse and the rising level after that request.
// Configuration (APB): pulses per set at byte address 0, level limit at byte address 4.
// Registers are to be written only while no request is in flight; the block does not enforce it.
// A request is held first in the input register, then the result register holds the
// sequencer state and the finished flag.
// Throughput: one transfer per cycle while the receiver does not stall. All of the work
// for a request sits in one pass of combinational logic between those two registers.
// When the receiver stalls, the result holds and one further request can still be taken
// into the input register; after that in_ready falls until the result is transferred.
// Reset (synchronous, active low) empties both stages, returns the sequencer to idle
// with both motor lines low and reloads the configuration defaults.
module haptic_pattern_sequencer #(
  parameter int TICK_COUNT_WIDTH = haps_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_req_type,
  input  logic [3:0]                         in_pattern,
  input  logic [3:0]                         in_level,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_motor_ctl,
  output logic                               out_motor_enable,
  output logic                               out_active,
  output logic                               out_finished,
  output logic [3:0]                         out_current_level,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [haps_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [haps_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [haps_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  haps_pkg::cfg_t                  cfg;

  // Input register stage.
  logic                            req_valid_r;
  haps_pkg::req_t                  req_type_r;
  logic [3:0]                      req_pattern_r;
  logic [3:0]                      req_level_r;

  // Sequencer state, which also forms the result register.
  haps_pkg::seq_state_t            st_r;
  haps_pkg::seq_state_t            st_nxt;
  logic [TICK_COUNT_WIDTH-1:0]     tick_cnt_r;
  logic [TICK_COUNT_WIDTH-1:0]     tick_cnt_nxt;
  logic                            finished_r;
  logic                            finished_nxt;
  logic                            out_valid_r;

  logic                            advance;
  logic                            in_fire;

  // The result stage moves on when it is empty or its transfer completes; the input
  // stage can take a new request whenever it is empty or is moving on itself.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !req_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  haps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r    <= haps_pkg::req_t'(in_req_type);
      req_pattern_r <= in_pattern;
      req_level_r   <= in_level;
    end
  end

  haps_step #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_step (
    .req          (req_type_r),
    .pattern      (req_pattern_r),
    .level        (req_level_r),
    .cfg          (cfg),
    .st           (st_r),
    .tick_cnt     (tick_cnt_r),
    .st_nxt       (st_nxt),
    .tick_cnt_nxt (tick_cnt_nxt),
    .finished     (finished_nxt)
  );

  // The state is committed only when the request moves into the result stage, so the
  // lines and flags on the result ports always belong to the request being offered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      st_r        <= haps_pkg::ST_RESET;
      tick_cnt_r  <= '0;
      finished_r  <= 1'b0;
    end else if (advance) begin
      out_valid_r <= req_valid_r;
      if (req_valid_r) begin
        st_r       <= st_nxt;
        tick_cnt_r <= tick_cnt_nxt;
        finished_r <= finished_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_motor_ctl     = st_r.line_ctl;
  assign out_motor_enable  = st_r.line_ena;
  assign out_active        = st_r.busy;
  assign out_finished      = finished_r;
  assign out_current_level = st_r.strength_level;

endmodule

// ===== design/haps_cfg.sv =====
module haps_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [haps_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [haps_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [haps_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output haps_pkg::cfg_t                     cfg
);

  logic [3:0] pps_r;
  logic [3:0] limit_r;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pps_r   <= haps_pkg::PPS_RESET;
      limit_r <= haps_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      if (reg_sel == haps_pkg::REG_PULSES_PER_SET) begin
        pps_r <= pwdata[3:0];
      end else begin
        limit_r <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == haps_pkg::REG_PULSES_PER_SET) begin
      prdata = haps_pkg::CFG_DATA_W'(pps_r);
    end else begin
      prdata = haps_pkg::CFG_DATA_W'(limit_r);
    end
  end

  assign cfg.pulses_per_set = pps_r;
  assign cfg.level_limit    = limit_r;

endmodule

// ===== design/haps_step.sv =====
module haps_step #(
  parameter int TICK_COUNT_WIDTH = haps_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  haps_pkg::req_t               req,
  input  logic [3:0]                   pattern,
  input  logic [3:0]                   level,
  input  haps_pkg::cfg_t               cfg,
  input  haps_pkg::seq_state_t         st,
  input  logic [TICK_COUNT_WIDTH-1:0]  tick_cnt,
  output haps_pkg::seq_state_t         st_nxt,
  output logic [TICK_COUNT_WIDTH-1:0]  tick_cnt_nxt,
  output logic                         finished
);

  localparam int TW = TICK_COUNT_WIDTH;

  logic [TW-1:0] t;
  logic [3:0]    eff_pps;
  logic [1:0]    sets;
  logic          is_pulse;
  logic          rising;
  logic [6:0]    period;
  logic [6:0]    ena_off;
  logic [6:0]    ctl_off;
  logic [5:0]    pc_inc;
  logic          level_up_ok;

  assign t       = (tick_cnt == {TW{1'b1}}) ? tick_cnt : tick_cnt + TW'(1);
  assign eff_pps = (cfg.pulses_per_set == 4'd0) ? 4'd1 : cfg.pulses_per_set;
  assign pc_inc  = st.pulse_count + 6'd1;
  assign level_up_ok = ({1'b0, st.strength_level} + 5'd1) < {1'b0, cfg.level_limit};

  // Sets per pattern on a start, from the level being applied.
  always_comb begin
    case (haps_pkg::mode_t'(pattern))
      haps_pkg::MODE_WEAK:       sets = 2'd1;
      haps_pkg::MODE_DURING:     sets = 2'd2;
      haps_pkg::MODE_DURING_REP,
      haps_pkg::MODE_STRONG,
      haps_pkg::MODE_STRONG_REP: sets = 2'd3;
      haps_pkg::MODE_RISING: begin
        if (level < 4'd4) begin
          sets = 2'd1;
        end else if (level < 4'd8) begin
          sets = 2'd2;
        end else begin
          sets = 2'd3;
        end
      end
      default:                   sets = 2'd1;
    endcase
  end

  // Pulse shape for the current mode and level.
  always_comb begin
    is_pulse = 1'b0;
    rising   = 1'b0;
    period   = haps_pkg::T_PERIOD_A;
    ena_off  = haps_pkg::T_ENA_A;
    ctl_off  = haps_pkg::T_CTL_A;
    case (st.mode)
      haps_pkg::MODE_WEAK,
      haps_pkg::MODE_DURING,
      haps_pkg::MODE_DURING_REP,
      haps_pkg::MODE_STRONG: begin
        is_pulse = 1'b1;
      end
      haps_pkg::MODE_STRONG_REP: begin
        is_pulse = 1'b1;
        period   = haps_pkg::T_PERIOD_C;
        ena_off  = haps_pkg::T_ENA_C;
        ctl_off  = haps_pkg::T_CTL_C;
      end
      haps_pkg::MODE_RISING: begin
        is_pulse = 1'b1;
        rising   = 1'b1;
        if (st.strength_level >= 4'd12 || st.strength_level[1:0] == 2'd3) begin
          period  = haps_pkg::T_PERIOD_D;
          ena_off = haps_pkg::T_ENA_D;
          ctl_off = haps_pkg::T_CTL_D;
        end else if (st.strength_level[1:0] == 2'd1) begin
          period  = haps_pkg::T_PERIOD_B;
          ena_off = haps_pkg::T_ENA_B;
          ctl_off = haps_pkg::T_CTL_B;
        end else if (st.strength_level[1:0] == 2'd2) begin
          period  = haps_pkg::T_PERIOD_C;
          ena_off = haps_pkg::T_ENA_C;
          ctl_off = haps_pkg::T_CTL_C;
        end
      end
      default: begin
        is_pulse = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt       = st;
    tick_cnt_nxt = tick_cnt;
    finished     = 1'b0;
    case (req)
      haps_pkg::REQ_TICK: begin
        tick_cnt_nxt = t;
        if (!st.stopped && (st.pulse_count < st.pulse_target)) begin
          if (is_pulse) begin
            if (t >= TW'(period)) begin
              st_nxt.pulse_count = pc_inc;
              if (haps_pkg::DIV_TAB[eff_pps][pc_inc]) begin
                // End of a set: pause, or, on a rising pattern in confirm mode, step up a level.
                st_nxt.return_mode = st.mode;
                if (rising && st.confirm_mode && (pc_inc >= st.pulse_target) &&
                    level_up_ok) begin
                  st_nxt.strength_level = st.strength_level + 4'd1;
                  st_nxt.pulse_count    = 6'd0;
                  st_nxt.mode           = haps_pkg::MODE_LEVEL_PAUSE;
                end else begin
                  st_nxt.mode = haps_pkg::MODE_PAUSE;
                end
              end
              tick_cnt_nxt = '0;
            end
            if (t >= TW'(ena_off)) begin
              st_nxt.line_ena = 1'b0;
            end
            if (t >= TW'(ctl_off)) begin
              st_nxt.line_ctl = 1'b0;
            end else begin
              st_nxt.line_ctl = 1'b1;
              st_nxt.line_ena = 1'b1;
            end
          end else begin
            case (st.mode)
              haps_pkg::MODE_ON: begin
                st_nxt.line_ctl = 1'b1;
                st_nxt.line_ena = 1'b1;
              end
              haps_pkg::MODE_OFF: begin
                st_nxt.line_ctl = 1'b0;
                st_nxt.line_ena = 1'b0;
              end
              haps_pkg::MODE_STANDBY,
              haps_pkg::MODE_SENSING: begin
                if (t >= TW'((st.mode == haps_pkg::MODE_STANDBY) ?
                             haps_pkg::T_STANDBY : haps_pkg::T_SENSING)) begin
                  st_nxt.line_ctl = 1'b0;
                  st_nxt.line_ena = 1'b0;
                  st_nxt.stopped  = 1'b1;
                  tick_cnt_nxt    = '0;
                end else begin
                  st_nxt.line_ctl = 1'b1;
                  st_nxt.line_ena = 1'b1;
                end
              end
              haps_pkg::MODE_PAUSE,
              haps_pkg::MODE_LEVEL_PAUSE: begin
                if (t >= TW'((st.mode == haps_pkg::MODE_PAUSE) ?
                             haps_pkg::T_PAUSE : haps_pkg::T_LVL_PAUSE)) begin
                  st_nxt.mode  = st.return_mode;
                  tick_cnt_nxt = '0;
                end
              end
              default: begin
                st_nxt.mode = st.mode;
              end
            endcase
          end
        end else if (st.mode != haps_pkg::MODE_IDLE) begin
          st_nxt.mode           = haps_pkg::MODE_IDLE;
          st_nxt.return_mode    = haps_pkg::MODE_IDLE;
          st_nxt.confirm_mode   = 1'b0;
          st_nxt.strength_level = 4'd0;
          st_nxt.busy           = 1'b0;
          finished              = 1'b1;
        end
      end
      haps_pkg::REQ_STOP: begin
        st_nxt.stopped  = 1'b1;
        st_nxt.line_ctl = 1'b0;
        st_nxt.line_ena = 1'b0;
      end
      default: begin
        st_nxt.strength_level = level;
        st_nxt.mode           = haps_pkg::mode_t'(pattern);
        st_nxt.pulse_target   = 6'(sets) * 6'(eff_pps);
        st_nxt.pulse_count    = 6'd0;
        st_nxt.stopped        = 1'b0;
        st_nxt.busy           = 1'b1;
        tick_cnt_nxt          = '0;
        if (req == haps_pkg::REQ_START_CONFIRM) begin
          st_nxt.confirm_mode = 1'b1;
        end
      end
    endcase
  end

endmodule

// ===== design/haps_checker.sv =====
`include "haptic_pattern_sequencer_defines.svh"

module haps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_motor_ctl,
  input logic       out_motor_enable,
  input logic       out_active,
  input logic       out_finished,
  input logic [3:0] out_current_level,
  input logic       pready
);

  // A stalled result keeps its value.
  `HPS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_motor_ctl) && $stable(out_motor_enable) && $stable(out_active) && $stable(out_finished) && $stable(out_current_level), "stalled result changed")

  // Completion clears the busy flag and the rising level together.
  `HPS_ASSERT(a_fin_idle, out_valid && out_finished |-> !out_active && out_current_level == 4'd0, "finished while still active")

  // With the result stage empty the block must take requests.
  `HPS_ASSERT(a_ready_empty, !out_valid |-> in_ready, "request refused with empty output")

  // Reset empties the pipeline.
  `HPS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result offered after reset")

  // The configuration port never inserts wait states.
  `HPS_ASSERT(a_pready, pready, "pready low")

endmodule

bind haptic_pattern_sequencer haps_checker u_haps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_motor_ctl     (out_motor_ctl),
  .out_motor_enable  (out_motor_enable),
  .out_active        (out_active),
  .out_finished      (out_finished),
  .out_current_level (out_current_level),
  .pready            (pready)
);

// ===== verif/tb_haptic_pattern_sequencer.sv =====
module tb_haptic_pattern_sequencer;
  import haps_pkg::*;

  // One result transfer as the checker sees it.
  typedef struct packed {
    logic       ctl;
    logic       ena;
    logic       act;
    logic       fin;
    logic [3:0] lvl;
  } motor_view_t;

  // One row of the directed table. Where typed is set, want is the result read
  // straight off the behaviour; otherwise the predictor supplies it.
  typedef struct packed {
    req_t        req;
    logic [3:0]  pat;
    logic [3:0]  lvl;
    logic        typed;
    motor_view_t want;
  } dir_row_t;

  localparam int QUIET_LIMIT = 2000;
  localparam int TICK_MAX    = (1 << TICK_COUNT_WIDTH_DEF) - 1;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 130;
  localparam int PRINT_MAX   = 40;

  // Pattern codes above the named modes act like idle, but complete once stopped.
  localparam logic [3:0] PAT_UNNAMED = 4'd15;

  // Settings per phase; the final phase draws its own at random.
  localparam logic [3:0] PHASE_PPS   [PHASES] = '{4'd1, 4'd0, 4'd2, 4'd15, 4'd1, 4'd3};
  localparam logic [3:0] PHASE_LIMIT [PHASES] = '{4'd3, 4'd0, 4'd15, 4'd12, 4'd1, 4'd12};

  localparam int DIR_ROWS = 25;
  localparam dir_row_t PLAN [DIR_ROWS] = '{
    // Straight out of reset: nothing runs, a stop in idle changes nothing visible.
    '{REQ_TICK,          MODE_IDLE,     4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd0}},
    '{REQ_STOP,          MODE_IDLE,     4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd0}},
    '{REQ_TICK,          MODE_IDLE,     4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 4'd0}},
    // Steady on at the top level code, stopped, then completed by a tick.
    '{REQ_START,         MODE_ON,       4'd15, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 4'd15}},
    '{REQ_TICK,          MODE_ON,       4'd15, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 4'd15}},
    '{REQ_STOP,          MODE_ON,       4'd15, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 4'd15}},
    '{REQ_TICK,          MODE_ON,       4'd15, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 4'd0}},
    // Idle start: active rises and stays, since idle never completes.
    '{REQ_START,         MODE_IDLE,     4'd0,  1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 4'd0}},
    '{REQ_TICK,          MODE_IDLE,     4'd0,  1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 4'd0}},
    // Undefined pattern with confirm: nothing on ticks, completes once stopped.
    '{REQ_START_CONFIRM, PAT_UNNAMED,   4'd12, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 4'd12}},
    '{REQ_TICK,          PAT_UNNAMED,   4'd12, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 4'd12}},
    '{REQ_STOP,          PAT_UNNAMED,   4'd12, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 4'd12}},
    '{REQ_TICK,          PAT_UNNAMED,   4'd12, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 4'd0}},
    // The remaining operations, left to the predictor.
    '{REQ_START,         MODE_STANDBY,  4'd11, 1'b0, '0},
    '{REQ_TICK,          MODE_STANDBY,  4'd11, 1'b0, '0},
    '{REQ_START_CONFIRM, MODE_RISING,   4'd12, 1'b0, '0},
    '{REQ_TICK,          MODE_RISING,   4'd12, 1'b0, '0},
    '{REQ_START,         MODE_WEAK,     4'd0,  1'b0, '0},
    '{REQ_TICK,          MODE_WEAK,     4'd0,  1'b0, '0},
    '{REQ_START,         MODE_SENSING,  4'd3,  1'b0, '0},
    '{REQ_TICK,          MODE_SENSING,  4'd3,  1'b0, '0},
    '{REQ_START,         MODE_OFF,      4'd7,  1'b0, '0},
    '{REQ_TICK,          MODE_OFF,      4'd7,  1'b0, '0},
    '{REQ_STOP,          MODE_OFF,      4'd7,  1'b0, '0},
    '{REQ_TICK,          MODE_OFF,      4'd7,  1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_req_type = REQ_TICK;
  logic [3:0]            in_pattern  = MODE_IDLE;
  logic [3:0]            in_level    = 4'd0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic                  out_motor_ctl;
  logic                  out_motor_enable;
  logic                  out_active;
  logic                  out_finished;
  logic [3:0]            out_current_level;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr       = '0;
  logic [CFG_DATA_W-1:0] pwdata      = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  haptic_pattern_sequencer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_pattern        (in_pattern),
    .in_level          (in_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motor_ctl     (out_motor_ctl),
    .out_motor_enable  (out_motor_enable),
    .out_active        (out_active),
    .out_finished      (out_finished),
    .out_current_level (out_current_level),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Results still owed by the block, oldest first.
  motor_view_t motor_q[$];

  int err_cnt   = 0;
  int sent      = 0;
  int in_burst  = 0;
  int out_burst = 0;
  int quiet_cnt = 0;

  // Shadow of the sequencer, starting from its reset state. The configuration
  // copy follows every register write made below.
  logic [3:0] pps_q     = PPS_RESET;
  logic [3:0] limit_q   = LIMIT_RESET;
  logic [3:0] seq_mode  = MODE_IDLE;
  logic [3:0] back_mode = MODE_IDLE;
  logic [3:0] level_q   = 4'd0;
  int         tick_q    = 0;
  logic [5:0] pulses_q  = 6'd0;
  logic [5:0] target_q  = 6'(PPS_RESET);
  logic       halted_q  = 1'b0;
  logic       confirm_q = 1'b0;
  logic       ctl_q     = 1'b0;
  logic       ena_q     = 1'b0;
  logic       busy_q    = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= PRINT_MAX) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // A pulses-per-set of zero counts as one.
  function automatic int per_set();
    return (pps_q == 4'd0) ? 1 : int'(pps_q);
  endfunction

  // One tick of a pulse pattern. When the period runs out a pulse is counted,
  // and a completed set moves to a pause; with confirm on a rising pattern that
  // has reached its target, with the next level below the limit, the level steps
  // up and the longer pause follows. The target itself is left as it was.
  function automatic void pulse_step(input int t, input int period, input int ena_off,
                                     input int ctl_off, input bit rising);
    if (t >= period) begin
      pulses_q = pulses_q + 6'd1;
      if (int'(pulses_q) % per_set() == 0) begin
        back_mode = seq_mode;
        if (rising && confirm_q && pulses_q >= target_q &&
            int'(level_q) + 1 < int'(limit_q)) begin
          level_q  = level_q + 4'd1;
          pulses_q = 6'd0;
          seq_mode = MODE_LEVEL_PAUSE;
        end else begin
          seq_mode = MODE_PAUSE;
        end
      end
      tick_q = 0;
    end
    if (t >= ena_off) ena_q = 1'b0;
    if (t >= ctl_off) begin
      ctl_q = 1'b0;
    end else begin
      ctl_q = 1'b1;
      ena_q = 1'b1;
    end
  endfunction

  // Standby and sensing: the motor runs until the length is reached, then the
  // pattern marks itself stopped so that the next tick completes it.
  function automatic void single_step(input int t, input int len);
    if (t >= len) begin
      ctl_q    = 1'b0;
      ena_q    = 1'b0;
      halted_q = 1'b1;
      tick_q   = 0;
    end else begin
      ctl_q = 1'b1;
      ena_q = 1'b1;
    end
  endfunction

  function automatic void pause_step(input int t, input int len);
    if (t >= len) begin
      seq_mode = back_mode;
      tick_q   = 0;
    end
  endfunction

  // Advances the shadow by one request and returns the result it must produce.
  function automatic motor_view_t step_sequencer(input req_t req, input logic [3:0] pat,
                                                 input logic [3:0] lvl);
    int          t;
    int          sets;
    logic        done;
    motor_view_t res;
    done = 1'b0;
    if (req == REQ_TICK) begin
      if (tick_q < TICK_MAX) tick_q++;
      t = tick_q;
      if (!halted_q && pulses_q < target_q) begin
        case (seq_mode)
          MODE_ON: begin
            ctl_q = 1'b1;
            ena_q = 1'b1;
          end
          MODE_OFF: begin
            ctl_q = 1'b0;
            ena_q = 1'b0;
          end
          MODE_WEAK, MODE_DURING, MODE_DURING_REP, MODE_STRONG:
            pulse_step(t, T_PERIOD_A, T_ENA_A, T_CTL_A, 1'b0);
          MODE_STRONG_REP:
            pulse_step(t, T_PERIOD_C, T_ENA_C, T_CTL_C, 1'b0);
          MODE_RISING: begin
            // Levels twelve and up all use the longest pulse shape.
            if (level_q >= 4'd12) begin
              pulse_step(t, T_PERIOD_D, T_ENA_D, T_CTL_D, 1'b1);
            end else begin
              case (level_q[1:0])
                2'd0:    pulse_step(t, T_PERIOD_A, T_ENA_A, T_CTL_A, 1'b1);
                2'd1:    pulse_step(t, T_PERIOD_B, T_ENA_B, T_CTL_B, 1'b1);
                2'd2:    pulse_step(t, T_PERIOD_C, T_ENA_C, T_CTL_C, 1'b1);
                default: pulse_step(t, T_PERIOD_D, T_ENA_D, T_CTL_D, 1'b1);
              endcase
            end
          end
          MODE_STANDBY:     single_step(t, T_STANDBY);
          MODE_SENSING:     single_step(t, T_SENSING);
          MODE_PAUSE:       pause_step(t, T_PAUSE);
          MODE_LEVEL_PAUSE: pause_step(t, T_LVL_PAUSE);
          default: ;
        endcase
      end else if (seq_mode != MODE_IDLE) begin
        // Completion: back to idle. The lines, the counts and the stopped flag
        // are left as they stand.
        seq_mode  = MODE_IDLE;
        back_mode = MODE_IDLE;
        confirm_q = 1'b0;
        level_q   = 4'd0;
        busy_q    = 1'b0;
        done      = 1'b1;
      end
    end else if (req == REQ_STOP) begin
      halted_q = 1'b1;
      ctl_q    = 1'b0;
      ena_q    = 1'b0;
    end else begin
      level_q = lvl;
      case (pat)
        MODE_WEAK:                                   sets = 1;
        MODE_DURING:                                 sets = 2;
        MODE_DURING_REP, MODE_STRONG, MODE_STRONG_REP: sets = 3;
        MODE_RISING: sets = (lvl < 4'd4) ? 1 : (lvl < 4'd8) ? 2 : 3;
        default:                                     sets = 1;
      endcase
      tick_q    = 0;
      seq_mode  = pat;
      target_q  = 6'(sets * per_set());
      pulses_q  = 6'd0;
      halted_q  = 1'b0;
      busy_q    = 1'b1;
      if (req == REQ_START_CONFIRM) confirm_q = 1'b1;
    end
    res = '{ctl: ctl_q, ena: ena_q, act: busy_q, fin: done, lvl: level_q};
    return res;
  endfunction

  // Offers one request and holds it until the transfer. The gap before it is
  // drawn per request, with occasional bursts of back-to-back transfers. The
  // valid line is lowered only when a gap is taken, so that a request that
  // follows at once never sees valid dropped and raised in the same step.
  task automatic send_req(input req_t req, input logic [3:0] pat, input logic [3:0] lvl,
                          input logic typed, input motor_view_t want);
    int          gap;
    motor_view_t guess;
    if (in_burst > 0) begin
      in_burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 24) == 0) in_burst = $urandom_range(10, 60);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_pattern  <= pat;
    in_level    <= lvl;
    do @(posedge clk); while (in_ready !== 1'b1);
    guess = step_sequencer(req, pat, lvl);
    motor_q.push_back(typed ? want : guess);
    sent++;
  endtask

  // Each register is written and then read back over the configuration port.
  // It is only called once the block has nothing in flight. The port is left
  // idle at the end, so a following access starts cleanly.
  task automatic write_reg(input logic idx, input logic [3:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[3:0] !== val) report_mismatch("register read-back", prdata[3:0], val);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_PULSES_PER_SET) begin
      pps_q = val;
    end else begin
      limit_q = val;
    end
    @(posedge clk);
  endtask

  // Stops offering requests and waits until every owed result has arrived,
  // then waits on for the number given in extra, to cover the two register stages.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (motor_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // One pattern run: a start, then mostly ticks until the shadow says the
  // pattern has completed. Now and then a stop or a random request breaks in.
  // Patterns that never complete on their own, and a share of the others, get
  // a short run; one still busy at the end may be stopped so its completion is seen.
  task automatic run_episode(input int stop_at);
    logic [3:0] pat;
    logic [3:0] lvl;
    int         cap;
    int         n;
    int         k;
    pat = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                      : 4'($urandom_range(1, 12));
    lvl = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(12, 15))
                                      : 4'($urandom_range(0, 11));
    send_req($urandom_range(0, 1) ? REQ_START_CONFIRM : REQ_START, pat, lvl, 1'b0, '0);
    if (pat < MODE_WEAK || pat > MODE_SENSING || $urandom_range(0, 3) == 0) begin
      cap = $urandom_range(2, 40);
    end else begin
      cap = 400;
    end
    n = 0;
    while (busy_q && n < cap && sent < stop_at) begin
      k = $urandom_range(0, 99);
      if (k < 2) begin
        send_req(REQ_STOP, 4'($urandom), 4'($urandom), 1'b0, '0);
      end else if (k < 4) begin
        send_req(req_t'($urandom_range(0, 3)), 4'($urandom), 4'($urandom), 1'b0, '0);
      end else begin
        send_req(REQ_TICK, 4'($urandom), 4'($urandom), 1'b0, '0);
      end
      n++;
    end
    if (busy_q && sent < stop_at && $urandom_range(0, 1) == 1) begin
      send_req(REQ_STOP, 4'($urandom), 4'($urandom), 1'b0, '0);
      send_req(REQ_TICK, 4'($urandom), 4'($urandom), 1'b0, '0);
    end
  endtask

  // Result side: a stall is drawn for every result, again with bursts of none.
  // Each transfer is compared field by field with the oldest owed result.
  initial begin : result_side
    int          stall;
    motor_view_t seen;
    motor_view_t want;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (out_burst > 0) begin
        out_burst--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 15);
        if ($urandom_range(0, 24) == 0) out_burst = $urandom_range(10, 60);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      seen = '{ctl: out_motor_ctl, ena: out_motor_enable, act: out_active,
               fin: out_finished, lvl: out_current_level};
      if (motor_q.size() == 0) begin
        report_mismatch("result with nothing owed", 1, 0);
      end else begin
        want = motor_q.pop_front();
        if (seen.ctl !== want.ctl) report_mismatch("motor_ctl", seen.ctl, want.ctl);
        if (seen.ena !== want.ena) report_mismatch("motor_enable", seen.ena, want.ena);
        if (seen.act !== want.act) report_mismatch("active", seen.act, want.act);
        if (seen.fin !== want.fin) report_mismatch("finished", seen.fin, want.fin);
        if (seen.lvl !== want.lvl) report_mismatch("current_level", seen.lvl, want.lvl);
      end
    end
  end

  // Watchdog: too long without a transfer on either channel ends the run.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cnt <= 0;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
      if (quiet_cnt >= QUIET_LIMIT) begin
        $display("tb_haptic_pattern_sequencer: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int         stop_at;
    logic [3:0] pps_val;
    logic [3:0] limit_val;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run with the configuration left at its reset values.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_req(PLAN[i].req, PLAN[i].pat, PLAN[i].lvl, PLAN[i].typed, PLAN[i].want);
    end

    // Random part in phases. Between phases the block is drained and both
    // registers are rewritten; the sequencer itself carries on from where it
    // was, which the shadow models too.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain(4);
      pps_val   = PHASE_PPS[ph];
      limit_val = PHASE_LIMIT[ph];
      if (ph == PHASES - 1) begin
        pps_val   = 4'($urandom_range(0, 4));
        limit_val = 4'($urandom_range(0, 15));
      end
      write_reg(REG_PULSES_PER_SET, pps_val);
      write_reg(REG_LEVEL_LIMIT, limit_val);
      stop_at = sent + PHASE_ITEMS;
      while (sent < stop_at) run_episode(stop_at);
    end

    drain(8);
    if (err_cnt == 0) begin
      $display("tb_haptic_pattern_sequencer: clean");
    end else begin
      $display("tb_haptic_pattern_sequencer: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/haps_pkg.sv
design/haps_cfg.sv
design/haps_step.sv
design/haptic_pattern_sequencer.sv
design/haps_checker.sv
verif/tb_haptic_pattern_sequencer.sv
